### design/ethernet_ping_reply_matcher_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ping reply matcher
// Shared concurrent-check forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ETHERNET_PING_REPLY_MATCHER_UNIT_DEFINES_SVH
`define ETHERNET_PING_REPLY_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EPRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EPRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/eprm_pkg.sv
// ---------------------------------------------------------------------------
// eprm_pkg
// Types and constants shared by the ping reply matcher modules.
// ---------------------------------------------------------------------------
package eprm_pkg;

   localparam int unsigned MAC_W      = 48;
   localparam int unsigned NET_W      = 32;
   localparam int unsigned PID_W      = 16;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned POS_W      = 5;

   // Frame layout (byte positions)
   localparam logic [POS_W-1:0] POS_SRC_FIRST = 5'd6;
   localparam logic [POS_W-1:0] POS_ETYPE_HI  = 5'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO  = 5'd13;
   localparam logic [POS_W-1:0] POS_NET_FIRST = 5'd14;
   localparam logic [POS_W-1:0] POS_MODE      = 5'd18;
   localparam logic [POS_W-1:0] POS_PID_LAST  = 5'd20;
   localparam logic [POS_W-1:0] CHECKED_LEN   = 5'd21;

   localparam logic [7:0] ETYPE_HI         = 8'h90;
   localparam logic [7:0] ETYPE_LO         = 8'h01;
   localparam logic [7:0] MODE_REPLY_UNI   = 8'h01;
   localparam logic [7:0] MODE_REPLY_BCAST = 8'h03;
   localparam logic [7:0] BCAST_BYTE       = 8'hff;
   localparam logic [MAC_W-1:0] BCAST_MAC  = {MAC_W{1'b1}};

   typedef enum logic [1:0] {
      CSR_OWN_MAC    = 2'd0,
      CSR_TARGET_MAC = 2'd1,
      CSR_NET_IDENT  = 2'd2,
      CSR_PING_IDENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_payload_type;

   typedef struct packed {
      logic [MAC_W-1:0] found_mac;
      logic             search_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [MAC_W-1:0] own_mac;
      logic [MAC_W-1:0] target_mac;
      logic [NET_W-1:0] net_ident;
      logic [PID_W-1:0] ping_ident;
   } cfg_type;

   typedef struct packed {
      logic            emit;
      logic            finished;
      rsp_payload_type rsp;
   } match_type;

endpackage

### design/eprm_csr.sv
// ---------------------------------------------------------------------------
// eprm_csr
// Configuration registers: own address, target address, network and packet id.
// ---------------------------------------------------------------------------
module eprm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [eprm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output eprm_pkg::cfg_type                 cfg
);
   import eprm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_OWN_MAC:    cfg_in.own_mac    = csr_write_data[MAC_W-1:0];
            CSR_TARGET_MAC: cfg_in.target_mac = csr_write_data[MAC_W-1:0];
            CSR_NET_IDENT:  cfg_in.net_ident  = csr_write_data[NET_W-1:0];
            CSR_PING_IDENT: cfg_in.ping_ident = csr_write_data[PID_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac    <= '0;
         cfg_ff.target_mac <= BCAST_MAC;
         cfg_ff.net_ident  <= '0;
         cfg_ff.ping_ident <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/eprm_frame_check.sv
// ---------------------------------------------------------------------------
// eprm_frame_check
// Per-byte header checks, source capture and match decision for one frame.
// ---------------------------------------------------------------------------
module eprm_frame_check (
   input  logic                      clock,
   input  logic                      reset,
   input  eprm_pkg::cfg_type         cfg,
   input  eprm_pkg::req_payload_type item,
   input  logic                      advance,
   output eprm_pkg::match_type       match
);
   import eprm_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             own_ok_ff, own_ok_in;
   logic             bc_ok_ff, bc_ok_in;
   logic             fields_ok_ff, fields_ok_in;
   logic [MAC_W-1:0] sender_ff, sender_in;
   logic             finished_ff, finished_in;

   logic             bcast_search;
   logic             own_hit;
   logic [2:0]       own_sel;
   logic [1:0]       net_sel;
   logic             pid_sel;
   logic             emit;

   assign bcast_search = (cfg.target_mac == BCAST_MAC);
   assign own_sel = 3'(5'd5 - pos_ff);
   assign net_sel = 2'(5'd17 - pos_ff);
   assign pid_sel = 1'(5'd20 - pos_ff);
   assign own_hit = (item.rx_byte == cfg.own_mac[{own_sel, 3'b000} +: 8]);

   always_comb begin
      own_ok_in    = own_ok_ff;
      bc_ok_in     = bc_ok_ff;
      fields_ok_in = fields_ok_ff;
      sender_in    = sender_ff;

      // Check the byte against what its position expects
      if (pos_ff < POS_SRC_FIRST) begin
         if (!own_hit)
            own_ok_in = 1'b0;
         if (item.rx_byte != BCAST_BYTE)
            bc_ok_in = 1'b0;
      end else if (pos_ff < POS_ETYPE_HI) begin
         sender_in = {sender_ff[MAC_W-9:0], item.rx_byte};
      end else if (pos_ff == POS_ETYPE_HI) begin
         if (item.rx_byte != ETYPE_HI)
            fields_ok_in = 1'b0;
      end else if (pos_ff == POS_ETYPE_LO) begin
         if (item.rx_byte != ETYPE_LO)
            fields_ok_in = 1'b0;
      end else if (pos_ff < POS_MODE) begin
         if (item.rx_byte != cfg.net_ident[{net_sel, 3'b000} +: 8])
            fields_ok_in = 1'b0;
      end else if (pos_ff == POS_MODE) begin
         if (item.rx_byte != (bcast_search ? MODE_REPLY_BCAST : MODE_REPLY_UNI))
            fields_ok_in = 1'b0;
      end else if (pos_ff < CHECKED_LEN) begin
         if (item.rx_byte != cfg.ping_ident[{pid_sel, 3'b000} +: 8])
            fields_ok_in = 1'b0;
      end

      emit = !finished_ff && item.rx_last && (pos_ff >= POS_PID_LAST)
             && (own_ok_in || bc_ok_in) && fields_ok_in;

      pos_in      = pos_ff;
      finished_in = finished_ff;
      if (!item.rx_last) begin
         if (pos_ff < CHECKED_LEN)
            pos_in = pos_ff + 5'd1;
      end else begin
         // Restart at the next frame
         pos_in       = '0;
         own_ok_in    = 1'b1;
         bc_ok_in     = 1'b1;
         fields_ok_in = 1'b1;
         if (emit && !bcast_search)
            finished_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         own_ok_ff    <= 1'b1;
         bc_ok_ff     <= 1'b1;
         fields_ok_ff <= 1'b1;
         sender_ff    <= '0;
         finished_ff  <= 1'b0;
      end else if (advance && !finished_ff) begin
         pos_ff       <= pos_in;
         own_ok_ff    <= own_ok_in;
         bc_ok_ff     <= bc_ok_in;
         fields_ok_ff <= fields_ok_in;
         sender_ff    <= sender_in;
         finished_ff  <= finished_in;
      end
   end

   assign match.emit            = emit;
   assign match.finished        = finished_ff;
   assign match.rsp.found_mac   = sender_in;
   assign match.rsp.search_done = !bcast_search;

endmodule

### design/eprm_out_reg.sv
// ---------------------------------------------------------------------------
// eprm_out_reg
// Result register: holds one result word until the consumer takes it.
// ---------------------------------------------------------------------------
module eprm_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  eprm_pkg::rsp_payload_type load_data,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output eprm_pkg::rsp_payload_type rsp_payload
);
   import eprm_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (valid_ff && !rsp_stall)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

### design/ethernet_ping_reply_matcher_unit.sv
// ---------------------------------------------------------------------------
// ethernet_ping_reply_matcher_unit
// Filters received frames for ping replies and reports the replying address.
// ---------------------------------------------------------------------------
// Received frame bytes enter one word per cycle on the req_ channel while
// req_stall is low, with rx_last marking the final byte of each frame. The
// block checks the destination address (own address or broadcast), the
// ethertype 0x9001, the 4-byte network id, the reply mode byte (3 for a
// broadcast target, 1 otherwise) and the 2-byte packet id. A frame of at
// least 21 bytes that passes every check yields one rsp_ word carrying its
// source address; in unicast search that word has search_done set and all
// later bytes are swallowed until reset. Throughput is one byte per cycle
// while no stall is raised; each byte is checked in the input register,
// and a match result is loaded into the result register, which drives
// rsp_valid. req_stall rises only when a result is ready to load while
// the previous one is still stalled on the rsp_ side. Configuration is
// written through the csr_ port; the user must do so only while the block
// is idle, which the block does not enforce; no clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "ethernet_ping_reply_matcher_unit_defines.svh"

module ethernet_ping_reply_matcher_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration writes
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [eprm_pkg::CSR_DATA_W-1:0] csr_write_data,
   // Frame bytes in
   input  logic                            req_valid,
   output logic                            req_stall,
   input  eprm_pkg::req_payload_type       req_payload,
   // Match results out
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output eprm_pkg::rsp_payload_type       rsp_payload
);
   import eprm_pkg::*;

   cfg_type         cfg;
   match_type       match;

   // Input register
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;

   logic            req_accept;
   logic            advance;
   logic            out_free;
   logic            out_load;

   eprm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   eprm_frame_check u_check (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (s1_data_ff),
      .advance (advance),
      .match   (match)
   );

   // Advance the held byte unless its result would collide with a stalled one
   assign advance    = s1_valid_ff && (!match.emit || out_free);
   assign out_load   = advance && match.emit;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_payload;
      end
   end

   eprm_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (out_load),
      .load_data   (match.rsp),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Stall only while a byte is held and blocked
   `EPRM_ASSERT_SAME(a_stall_needs_held, clock, reset, req_stall, s1_valid_ff,
                     "req_stall without a held byte")
   // A unicast match ends the search on the next cycle
   `EPRM_ASSERT_NEXT(a_unicast_ends, clock, reset, out_load && match.rsp.search_done,
                     match.finished, "unicast match did not end search")
   // No result once the search has ended
   `EPRM_ASSERT_SAME(a_no_emit_finished, clock, reset, match.finished, !match.emit,
                     "result after search ended")

endmodule
